FILE: sv/bgi_pkg.sv
// Shared types and constants of the bilinear grid interpolator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package bgi_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      REG_X_MIN     = 3'd0,
      REG_X_MAX     = 3'd1,
      REG_Y_MIN     = 3'd2,
      REG_Y_MAX     = 3'd3,
      REG_X_SCALE   = 3'd4,
      REG_Y_SCALE   = 3'd5,
      REG_ROW_COUNT = 3'd6,
      REG_COL_COUNT = 3'd7
   } csr_reg_type;

   // Configuration of one axis as seen by the locate pipeline.
   typedef struct packed {
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic [31:0]        scale;
      logic [6:0]         count;
   } axis_cfg_type;

   // Index width for a grid dimension; at least two bits so that the
   // row or column halves used for bank addressing are never empty.
   function automatic int idx_width(input int n);
      int w;
      w = $clog2(n);
      if (w < 2) begin
         w = 2;
      end
      return w;
   endfunction

endpackage

FILE: sv/bgi_locate.sv
// Three-stage locate pipeline for one axis: clamp, scale, index split.
// Depends on bgi_pkg for the axis configuration struct.
`timescale 1ns / 1ps

module bgi_locate import bgi_pkg::*; #(
   parameter int MAX_N = DEF_MAX_ROWS,
   parameter int IW    = idx_width(MAX_N)
) (
   input  logic               clock,
   input  logic               adv,
   input  axis_cfg_type       cfg,
   input  logic signed [31:0] coord,
   output logic [IW-1:0]      idx,
   output logic [16:0]        frac
);

   logic signed [32:0] q33, lo33, hi33, hi_m1, c0, c1;
   logic signed [33:0] off34;
   logic [31:0]        off_in, off_ff;
   logic [47:0]        prod_ff;
   logic [63:0]        prod_full;
   logic [31:0]        cnt32, lim32, raw_idx, sel_idx;
   logic [16:0]        frac_in, frac_ff;
   logic [IW-1:0]      idx_ff;

   // Stage A: clamp to [lo, hi - 1 LSB], min first, and take the offset.
   always_comb begin
      q33   = 33'(coord);
      lo33  = 33'(cfg.lo);
      hi33  = 33'(cfg.hi);
      hi_m1 = hi33 - 33'sd1;
      c0    = (q33 <= lo33) ? lo33 : q33;
      c1    = (c0 >= hi33) ? hi_m1 : c0;
      off34 = 34'(c1) - 34'(lo33);
      off_in = off34[33] ? 32'd0 : off34[31:0];
   end

   assign prod_full = 64'(off_ff) * 64'(cfg.scale);

   // Stage C: limit the cell index to the last cell of the grid in use.
   always_comb begin
      cnt32 = 32'(cfg.count);
      if (cnt32 < 32'd2) begin
         lim32 = 32'd0;
      end else if (cnt32 > 32'(MAX_N)) begin
         lim32 = 32'(MAX_N - 2);
      end else begin
         lim32 = cnt32 - 32'd2;
      end
      raw_idx = prod_ff[47:16];
      if (raw_idx > lim32) begin
         sel_idx = lim32;
         frac_in = ONE_Q16;
      end else begin
         sel_idx = raw_idx;
         frac_in = {1'b0, prod_ff[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         off_ff  <= off_in;
         prod_ff <= prod_full[63:16];
         idx_ff  <= sel_idx[IW-1:0];
         frac_ff <= frac_in;
      end
   end

   assign idx  = idx_ff;
   assign frac = frac_ff;

endmodule

FILE: sv/bgi_grid_mem.sv
// Grid store in four banks split by row and column parity, so the four
// corners of a cell are read in the same cycle. Depends on bgi_pkg.
`timescale 1ns / 1ps

module bgi_grid_mem import bgi_pkg::*; #(
   parameter int RW = idx_width(DEF_MAX_ROWS),
   parameter int CW = idx_width(DEF_MAX_COLS)
) (
   input  logic          clock,
   input  logic          adv,
   input  logic          wr_en,
   input  logic [RW-1:0] wr_row,
   input  logic [CW-1:0] wr_col,
   input  logic [31:0]   wr_data,
   input  logic [RW-1:0] rd_row,
   input  logic [CW-1:0] rd_col,
   output logic [31:0]   rd_data [4]
);

   localparam int AW    = RW - 1 + CW - 1;
   localparam int DEPTH = 1 << AW;

   logic [RW-1:0] row_up;
   logic [CW-1:0] col_up;
   logic [RW-2:0] half_row [2];
   logic [CW-2:0] half_col [2];

   // Even bank holds xi or xi+1, whichever is even; same for columns.
   always_comb begin
      row_up      = rd_row + RW'(rd_row[0]);
      col_up      = rd_col + CW'(rd_col[0]);
      half_row[0] = row_up[RW-1:1];
      half_row[1] = rd_row[RW-1:1];
      half_col[0] = col_up[CW-1:1];
      half_col[1] = rd_col[CW-1:1];
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [31:0]   mem [DEPTH];
      logic [31:0]   rd_ff;
      logic          bank_wr;
      logic [AW-1:0] rd_addr;

      assign bank_wr = wr_en && (wr_row[0] == b[1]) && (wr_col[0] == b[0]);
      assign rd_addr = {half_row[b / 2], half_col[b % 2]};

      always_ff @(posedge clock) begin
         if (adv) begin
            if (bank_wr) begin
               mem[{wr_row[RW-1:1], wr_col[CW-1:1]}] <= wr_data;
            end
            rd_ff <= mem[rd_addr];
         end
      end

      assign rd_data[b] = rd_ff;
   end

endmodule

FILE: sv/bgi_blend.sv
// Two-stage bilinear blend: x blend of both column pairs, then y blend
// with rounding to Q16.16. Depends on bgi_pkg.
`timescale 1ns / 1ps

module bgi_blend import bgi_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic [31:0]        bank_data [4],
   input  logic               xi_odd,
   input  logic               yi_odd,
   input  logic [16:0]        xf,
   input  logic [16:0]        yf,
   output logic signed [31:0] result
);

   logic signed [31:0] s00, s10, s01, s11;
   logic signed [17:0] wx0, wx1, wy0_in, wy1_in;
   logic signed [50:0] a0_in, a1_in, a0_ff, a1_ff;
   logic signed [17:0] wy0_ff, wy1_ff;
   logic signed [69:0] sum;
   logic signed [69:0] sum_rnd;

   // Bank number is {row parity, column parity}.
   always_comb begin
      s00    = bank_data[{xi_odd, yi_odd}];
      s10    = bank_data[{~xi_odd, yi_odd}];
      s01    = bank_data[{xi_odd, ~yi_odd}];
      s11    = bank_data[{~xi_odd, ~yi_odd}];
      wx1    = $signed({1'b0, xf});
      wx0    = $signed({1'b0, ONE_Q16 - xf});
      wy1_in = $signed({1'b0, yf});
      wy0_in = $signed({1'b0, ONE_Q16 - yf});
      a0_in  = 51'(s00 * wx0) + 51'(s10 * wx1);
      a1_in  = 51'(s01 * wx0) + 51'(s11 * wx1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a0_ff  <= a0_in;
         a1_ff  <= a1_in;
         wy0_ff <= wy0_in;
         wy1_ff <= wy1_in;
      end
   end

   // Round half up: add half an output LSB, keep bits 63..32.
   always_comb begin
      sum     = 70'(a0_ff * wy0_ff) + 70'(a1_ff * wy1_ff);
      sum_rnd = sum + 70'sh80000000;
      result  = sum_rnd[63:32];
   end

endmodule

FILE: sv/bilinear_grid_interpolator.sv
// Top level of the bilinear grid interpolator: configuration registers,
// pipeline control and output register. Uses bgi_pkg and all bgi_ modules.
`timescale 1ns / 1ps

// Usage.
// The request channel (req_valid / req_stall) carries one beat per item.
// A beat with req_op = OP_WRITE stores req_sample_value at grid word
// (req_row_index, req_col_index) and gives no response; rows or columns
// beyond the grid size are dropped. A beat with req_op = OP_QUERY carries
// a point (req_query_x, req_query_y) and gives exactly one response beat
// on rsp_valid / rsp_stall, carrying the blended value rsp_interp_value.
// Responses come in request order.
// The pipeline takes one beat every cycle unless it is held by rsp_stall.
// A query's response passes through the register stages in order: clamp,
// scale multiply, index split, grid bank read and x blend each own a
// register stage, and the y blend with rounding feeds the response
// register. The four corners come from four parity banks in the same
// cycle, which is what holds the rate at one beat per cycle.
// Writes travel the same pipeline and reach the grid at the read stage,
// so a query always sees every write taken before it.
// When the response register is full and rsp_stall is high, the whole
// pipeline holds and req_stall is raised; nothing is lost or repeated.
// The csr_ channel writes a register at csr_index with csr_wdata; it is
// always ready and must only be used while the block is idle.
// Reset clears the pipeline and the response register and loads the
// register defaults; the grid itself is not cleared and must be written
// before it is read.
module bilinear_grid_interpolator import bgi_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [5:0]         req_row_index,
   input  logic [5:0]         req_col_index,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_interp_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int RW = idx_width(MAX_ROWS);
   localparam int CW = idx_width(MAX_COLS);

   // Configuration registers.
   logic signed [31:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic [31:0]        x_scale_ff, y_scale_ff;
   logic [6:0]         row_count_ff, col_count_ff;
   axis_cfg_type       x_cfg, y_cfg;

   // Pipeline control: stages A, B, C, D (grid read), E (x blend).
   logic [4:0]         vld_ff;
   logic [4:0]         qry_ff;
   logic               adv;
   logic               req_take;
   logic               wr_ok_in;
   logic [2:0]         wok_ff;
   logic [RW-1:0]      wrow_ff [3];
   logic [CW-1:0]      wcol_ff [3];
   logic [31:0]        wdat_ff [3];

   logic [RW-1:0]      xi;
   logic [CW-1:0]      yi;
   logic [16:0]        xf, yf, xf_d_ff, yf_d_ff;
   logic               xodd_d_ff, yodd_d_ff;
   logic [31:0]        bank_data [4];
   logic signed [31:0] blend_result;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff     <= 32'sd0;
         x_max_ff     <= 32'sd65536;
         y_min_ff     <= 32'sd0;
         y_max_ff     <= 32'sd65536;
         x_scale_ff   <= 32'd65536;
         y_scale_ff   <= 32'd65536;
         row_count_ff <= 7'd2;
         col_count_ff <= 7'd2;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_X_MIN:     x_min_ff     <= csr_wdata;
            REG_X_MAX:     x_max_ff     <= csr_wdata;
            REG_Y_MIN:     y_min_ff     <= csr_wdata;
            REG_Y_MAX:     y_max_ff     <= csr_wdata;
            REG_X_SCALE:   x_scale_ff   <= csr_wdata;
            REG_Y_SCALE:   y_scale_ff   <= csr_wdata;
            REG_ROW_COUNT: row_count_ff <= csr_wdata[6:0];
            REG_COL_COUNT: col_count_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign x_cfg = '{lo: x_min_ff, hi: x_max_ff, scale: x_scale_ff, count: row_count_ff};
   assign y_cfg = '{lo: y_min_ff, hi: y_max_ff, scale: y_scale_ff, count: col_count_ff};

   // The whole pipeline moves unless a finished response is held back.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign req_take  = req_valid && adv;

   // Writes outside the configured maximum grid are dropped here.
   assign wr_ok_in = (req_op == OP_WRITE) && (32'(req_row_index) < 32'(MAX_ROWS))
                     && (32'(req_col_index) < 32'(MAX_COLS));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], req_take};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qry_ff     <= {qry_ff[3:0], req_op == OP_QUERY};
         wok_ff     <= {wok_ff[1:0], wr_ok_in};
         wrow_ff[0] <= RW'(req_row_index);
         wcol_ff[0] <= CW'(req_col_index);
         wdat_ff[0] <= req_sample_value;
         wrow_ff[1] <= wrow_ff[0];
         wcol_ff[1] <= wcol_ff[0];
         wdat_ff[1] <= wdat_ff[0];
         wrow_ff[2] <= wrow_ff[1];
         wcol_ff[2] <= wcol_ff[1];
         wdat_ff[2] <= wdat_ff[1];
         xf_d_ff    <= xf;
         yf_d_ff    <= yf;
         xodd_d_ff  <= xi[0];
         yodd_d_ff  <= yi[0];
      end
   end

   bgi_locate #(.MAX_N(MAX_ROWS), .IW(RW)) u_locate_x (
      .clock (clock),
      .adv   (adv),
      .cfg   (x_cfg),
      .coord (req_query_x),
      .idx   (xi),
      .frac  (xf)
   );

   bgi_locate #(.MAX_N(MAX_COLS), .IW(CW)) u_locate_y (
      .clock (clock),
      .adv   (adv),
      .cfg   (y_cfg),
      .coord (req_query_y),
      .idx   (yi),
      .frac  (yf)
   );

   bgi_grid_mem #(.RW(RW), .CW(CW)) u_grid (
      .clock   (clock),
      .adv     (adv),
      .wr_en   (vld_ff[2] && !qry_ff[2] && wok_ff[2]),
      .wr_row  (wrow_ff[2]),
      .wr_col  (wcol_ff[2]),
      .wr_data (wdat_ff[2]),
      .rd_row  (xi),
      .rd_col  (yi),
      .rd_data (bank_data)
   );

   bgi_blend u_blend (
      .clock     (clock),
      .adv       (adv),
      .bank_data (bank_data),
      .xi_odd    (xodd_d_ff),
      .yi_odd    (yodd_d_ff),
      .xf        (xf_d_ff),
      .yf        (yf_d_ff),
      .result    (blend_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[4] && qry_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= blend_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_data_ff;

   // A held pipeline keeps its occupancy.
   a_hold_keeps_valids: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valids changed while held");

   // A response appears only for a query that left the x blend stage.
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vld_ff[4] && qry_ff[4]))
      else $error("response without a query");

   // Fractions never exceed one.
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      (xf <= ONE_Q16) && (yf <= ONE_Q16))
      else $error("fraction above one");

   // Cell indices keep the far corner inside the grid.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && qry_ff[2] |-> (32'(xi) <= 32'(MAX_ROWS - 2))
                                 && (32'(yi) <= 32'(MAX_COLS - 2)))
      else $error("cell index past last cell");

endmodule
